/* hdl/pvrp_pkg.sv */
package pvrp_pkg;

    // Default depth of the bitmap RAM, as an address width.
    localparam int RAM_ADDR_BITS_DEF = 14;

    // Configuration port geometry: two 64-bit registers at byte addresses 0 and 8.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;

    // Register indexes, taken from paddr bit 3.
    localparam logic REG_TWO_BIT_MASKS   = 1'b0;
    localparam logic REG_THIRD_BIT_MASKS = 1'b1;

    // Access kinds carried on the input tuser.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // Offset bits 15..13 all set select the third-plane path.
    localparam logic [2:0] THIRD_PLANE_SEL = 3'b111;

    // The scattered third-plane address is 11 bits wide.
    localparam int P3_ADDR_W = 11;

    // Read results keep bits 4..0 set.
    localparam logic [4:0] READ_LOW_ONES = 5'h1f;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_MAIN,
        ST_MG_MAIN,
        ST_RD_P3,
        ST_MG_P3
    } t_state;

    // Operands of the shared merge and test unit.
    typedef struct packed {
        logic [7:0] rd_data;
        logic [7:0] pattern;
        logic [7:0] keep;
        logic [7:0] sel;
    } t_merge_req;

    // Results of the shared merge and test unit.
    typedef struct packed {
        logic [7:0] merged;
        logic       hit_hi;
        logic       hit_lo;
    } t_merge_rsp;

    // Third-plane byte: {p11, ~p11, p10..p3, p12}.
    function automatic logic [P3_ADDR_W-1:0] plane3_addr(input logic [15:0] p);
        plane3_addr = {p[11], ~p[11], p[10:3], p[12]};
    endfunction

endpackage

/* hdl/pvrp_merge.sv */
module pvrp_merge
    import pvrp_pkg::*;
(
    input  t_merge_req i_req,
    output t_merge_rsp o_rsp
);

    logic [7:0] hit;

    // A set keep bit holds the old RAM bit, a clear one takes the pattern bit.
    assign o_rsp.merged = (i_req.rd_data & i_req.keep) | (i_req.pattern & ~i_req.keep);

    assign hit          = i_req.rd_data & i_req.sel;
    assign o_rsp.hit_hi = |hit[7:4];
    assign o_rsp.hit_lo = |hit[3:0];

endmodule

/* hdl/pvrp_bitmap.sv */
module pvrp_bitmap
    import pvrp_pkg::*;
#(
    parameter int ADDR_BITS = RAM_ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [7:0]           o_rd_data,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [7:0]           i_wr_data
);

    logic [7:0] r_mem [0:(1 << ADDR_BITS)-1];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/planar_video_ram_port.sv */
// Pixel port into a byte-wide bitmap RAM of 2**RAM_ADDR_BITS bytes. Each input beat names
// a pixel by a 16-bit offset and is either a write (tuser low) or a read (tuser high). A
// write expands colour bits 7..6 of the data into a nibble pattern and merges it into byte
// offset>>2 under the two-plane mask byte picked by offset bits 2..0; a 1 in a mask keeps
// the old bit. When offset bits 15..13 are all set, a write also merges data bit 5 into a
// scattered third-plane byte under the third-plane mask. A read returns 0xFF with bit 7,
// bit 6 and (on the third-plane path) bit 5 cleared for pixel bits that are zero; a write
// returns zero. Every input beat yields exactly one output beat, whose tuser flags the
// third-plane path. One read-modify-write sequencer drives the RAM's read and write ports
// and a single merge unit: an item steps through accept, RAM read, and merge and write
// back; the third-plane path adds its own RAM read and merge for the second byte. The
// last merge and write back wait until the output register is free. The next item is
// accepted once the sequencer is back in idle, even while the previous result still
// waits in the output register. After reset the RAM is cleared one byte a cycle; no item
// is accepted during that pass, while configuration writes are taken at any time.
module planar_video_ram_port
    import pvrp_pkg::*;
#(
    parameter int RAM_ADDR_BITS = RAM_ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // [15:0] pixel_offset, [23:16] pixel_data
    input  logic                  s_axis_tuser,   // [0] mode

    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] read_value
    output logic                  m_axis_tuser,   // [0] third_plane_used

    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Configuration registers. Register index is paddr bit 3 (8-byte stride).
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] r_two_masks;
    logic [CFG_DATA_W-1:0] r_third_masks;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_masks   <= '0;
            r_third_masks <= '0;
        end else if (cfg_wr) begin
            if (paddr[3] == REG_TWO_BIT_MASKS) begin
                r_two_masks <= pwdata;
            end else begin
                r_third_masks <= pwdata;
            end
        end
    end

    assign prdata = (paddr[3] == REG_TWO_BIT_MASKS) ? r_two_masks : r_third_masks;

    // ------------------------------------------------------------------
    // Sequencer state and the captured item.
    // ------------------------------------------------------------------
    t_state                 r_state, n_state;
    logic [RAM_ADDR_BITS-1:0] r_clr_addr, n_clr_addr;
    logic                   r_mode;
    logic [15:0]            r_off;
    logic [7:0]             r_data;
    logic [7:0]             r_result, n_result;
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_data, n_out_data;
    logic                   r_out_third, n_out_third;

    logic                   in_accept;
    logic                   out_free;
    logic                   third;
    logic [RAM_ADDR_BITS-1:0] main_addr;
    logic [RAM_ADDR_BITS-1:0] p3_addr;

    // RAM port and merge unit hookup.
    logic [RAM_ADDR_BITS-1:0] ram_rd_addr;
    logic [7:0]             ram_rd_data;
    logic                   ram_wr_en;
    logic [RAM_ADDR_BITS-1:0] ram_wr_addr;
    logic [7:0]             ram_wr_data;
    t_merge_req             mg_req;
    t_merge_rsp             mg_rsp;
    logic                   p3_pass;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign third     = (r_off[15:13] == THIRD_PLANE_SEL);
    assign main_addr = r_off[RAM_ADDR_BITS+1:2];
    assign p3_addr   = {{(RAM_ADDR_BITS-P3_ADDR_W){1'b0}}, plane3_addr(r_off)};

    // The read address is held through the merge state, so the read data stays valid
    // while the sequencer waits for the output register to drain.
    assign p3_pass     = (r_state == ST_RD_P3) || (r_state == ST_MG_P3);
    assign ram_rd_addr = p3_pass ? p3_addr : main_addr;

    // Operands of the shared unit for the pass at hand. The first pass tests the two
    // nibble bits of the pixel; the third-plane pass tests one bit picked by offset 2..0.
    always_comb begin
        mg_req.rd_data = ram_rd_data;
        if (p3_pass) begin
            mg_req.pattern = {8{r_data[5]}};
            mg_req.keep    = r_third_masks[{r_off[2:0], 3'b000} +: 8];
            mg_req.sel     = 8'(1) << r_off[2:0];
        end else begin
            mg_req.pattern = {{4{r_data[7]}}, {4{r_data[6]}}};
            mg_req.keep    = r_two_masks[{r_off[2:0], 3'b000} +: 8];
            mg_req.sel     = 8'h11 << r_off[1:0];
        end
    end

    pvrp_merge u_merge (
        .i_req (mg_req),
        .o_rsp (mg_rsp)
    );

    pvrp_bitmap #(
        .ADDR_BITS (RAM_ADDR_BITS)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data)
    );

    // Next state and datapath controls. A write back in the last merge state happens
    // only together with loading the result, so a stall never writes twice.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_result    = r_result;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_third = r_out_third;
        ram_wr_en   = 1'b0;
        ram_wr_addr = main_addr;
        ram_wr_data = mg_rsp.merged;

        case (r_state)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_addr;
                ram_wr_data = '0;
                n_clr_addr  = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_RD_MAIN;
                end
            end
            ST_RD_MAIN: begin
                n_state = ST_MG_MAIN;
            end
            ST_MG_MAIN: begin
                n_result = {mg_rsp.hit_hi, mg_rsp.hit_lo, 1'b1, READ_LOW_ONES};
                if (third) begin
                    ram_wr_en = (r_mode == MODE_WRITE);
                    n_state   = ST_RD_P3;
                end else if (out_free) begin
                    ram_wr_en   = (r_mode == MODE_WRITE);
                    n_out_valid = 1'b1;
                    n_out_data  = (r_mode == MODE_WRITE) ? 8'h00 :
                                  {mg_rsp.hit_hi, mg_rsp.hit_lo, 1'b1, READ_LOW_ONES};
                    n_out_third = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            ST_RD_P3: begin
                n_state = ST_MG_P3;
            end
            ST_MG_P3: begin
                ram_wr_addr = p3_addr;
                if (out_free) begin
                    ram_wr_en   = (r_mode == MODE_WRITE);
                    n_out_valid = 1'b1;
                    n_out_data  = (r_mode == MODE_WRITE) ? 8'h00 :
                                  {r_result[7:6], mg_rsp.hit_hi | mg_rsp.hit_lo,
                                   READ_LOW_ONES};
                    n_out_third = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode <= s_axis_tuser;
            r_off  <= s_axis_tdata[15:0];
            r_data <= s_axis_tdata[23:16];
        end
        r_result    <= n_result;
        r_out_data  <= n_out_data;
        r_out_third <= n_out_third;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_third;

endmodule

/* hdl/pvrp_checker.sv */
module pvrp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser
);

    // Reset starts the clearing pass, so no input is taken right after it.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready right after reset");

    // One item at a time: ready drops after every accepted input beat.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready in the cycle after an accepted beat");

    // A result needs the RAM read latency: none appears in the cycle after acceptance.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared before the RAM read could finish");

    // Read results keep bits 4..0 set, and bit 5 too off the third-plane path.
    a_read_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata != 8'h00) |->
            (m_axis_tdata[4:0] == 5'h1f) && (m_axis_tuser || m_axis_tdata[5]))
        else $error("malformed read result");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

endmodule

bind planar_video_ram_port pvrp_checker u_pvrp_checker (.*);

/* verif/planar_video_ram_port_checker.sv */
`timescale 1ns / 100ps

// Watches the pixel stream, the result stream and the register port. It keeps a shadow
// of the bitmap RAM and both mask registers, and predicts one result per accepted pixel
// beat. Each result beat is compared with the oldest prediction still waiting.
module planar_video_ram_port_checker
    import pvrp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_tvalid,
    input  logic                  i_in_tready,
    input  logic [23:0]           i_in_tdata,     // [15:0] pixel_offset, [23:16] pixel_data
    input  logic                  i_in_tuser,     // [0] mode

    input  logic                  i_out_tvalid,
    input  logic                  i_out_tready,
    input  logic [7:0]            i_out_tdata,    // [7:0] read_value
    input  logic                  i_out_tuser,    // [0] third_plane_used

    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,

    output int                    o_errors,
    output int                    o_pending
);

    localparam int BITMAP_DEPTH = 1 << RAM_ADDR_BITS_DEF;

    typedef struct packed {
        logic [7:0] read_value;
        logic       third_plane;
    } t_pixel_result;

    logic [7:0]    bitmap_shadow [BITMAP_DEPTH];
    logic [63:0]   two_plane_keep;
    logic [63:0]   third_plane_keep;
    t_pixel_result pixel_results [$];
    t_pixel_result oldest_result;

    // Applies one pixel access to the shadow RAM and queues the result it must produce.
    task automatic predict_pixel_access(input logic mode, input logic [15:0] off,
                                        input logic [7:0] data);
        logic          third;
        logic [13:0]   main_addr;
        logic [10:0]   plane3_addr;
        logic [7:0]    keep;
        logic [7:0]    pattern;
        logic [7:0]    hit;
        t_pixel_result res;

        third       = (off[15:13] == THIRD_PLANE_SEL);
        main_addr   = off[15:2];
        // The third-plane byte is scattered: {p11, ~p11, p10..p3, p12}.
        plane3_addr = {off[11], ~off[11], off[10:3], off[12]};
        res.read_value  = 8'h00;
        res.third_plane = third;

        if (mode == MODE_WRITE) begin
            case (off[2:0] == 3'd0 ? data[7:6] : data[7:6])
                2'b00:   pattern = 8'h00;
                2'b01:   pattern = 8'h0f;
                2'b10:   pattern = 8'hf0;
                default: pattern = 8'hff;
            endcase
            keep = two_plane_keep[off[2:0]*8 +: 8];
            bitmap_shadow[main_addr] = (bitmap_shadow[main_addr] & keep) | (pattern & ~keep);
            if (third) begin
                pattern = {8{data[5]}};
                keep    = third_plane_keep[off[2:0]*8 +: 8];
                bitmap_shadow[plane3_addr] = (bitmap_shadow[plane3_addr] & keep) |
                                             (pattern & ~keep);
            end
        end else begin
            hit = bitmap_shadow[main_addr] & (8'h11 << off[1:0]);
            res.read_value = 8'hff;
            if (hit[7:4] == 4'h0) res.read_value[7] = 1'b0;
            if (hit[3:0] == 4'h0) res.read_value[6] = 1'b0;
            if (third && !bitmap_shadow[plane3_addr][off[2:0]]) res.read_value[5] = 1'b0;
        end
        pixel_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (bitmap_shadow[a]) bitmap_shadow[a] = 8'h00;
            two_plane_keep   = '0;
            third_plane_keep = '0;
            pixel_results.delete();
            o_errors = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[3] == REG_THIRD_BIT_MASKS) third_plane_keep = i_pwdata;
                else                                   two_plane_keep   = i_pwdata;
            end
            // A result can never belong to a beat accepted at the same edge, so the
            // comparison comes before the new prediction.
            if (i_out_tvalid && i_out_tready) begin
                if (pixel_results.size() == 0) begin
                    $display("%0t: unexpected result beat, read_value %02h third_plane %0b",
                             $time, i_out_tdata, i_out_tuser);
                    o_errors++;
                end else begin
                    oldest_result = pixel_results.pop_front();
                    if (i_out_tdata !== oldest_result.read_value) begin
                        $display("%0t: read_value mismatch, expected %02h actual %02h",
                                 $time, oldest_result.read_value, i_out_tdata);
                        o_errors++;
                    end
                    if (i_out_tuser !== oldest_result.third_plane) begin
                        $display("%0t: third_plane_used mismatch, expected %0b actual %0b",
                                 $time, oldest_result.third_plane, i_out_tuser);
                        o_errors++;
                    end
                end
            end
            if (i_in_tvalid && i_in_tready)
                predict_pixel_access(i_in_tuser, i_in_tdata[15:0], i_in_tdata[23:16]);
        end
        o_pending = pixel_results.size();
    end

endmodule

/* verif/planar_video_ram_port_tb.sv */
`timescale 1ns / 100ps

// Top of the pixel port testbench. It drives the pixel stream, the result-side ready and
// the register port, and leaves all prediction and comparison to the checker beside the
// block. Inputs change on the falling clock edge; the checker samples on the rising edge.
module planar_video_ram_port_tb;
    import pvrp_pkg::*;

    // The limit must cover the RAM clear after reset and a slow but correct run of about
    // 1100 beats, each with the longest idle gap and result stall; it leaves a wide margin.
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 8;
    localparam int BEATS_PER_PHASE = 135;
    localparam int DRAIN_CYCLES    = 16;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata;   // [15:0] pixel_offset, [23:16] pixel_data
    logic                  s_axis_tuser;   // [0] mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;   // [7:0] read_value
    logic                  m_axis_tuser;   // [0] third_plane_used
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int          error_count;
    int          results_waiting;
    int          cycle_count;
    int          stall_left;
    int          run_left;
    bit          no_idling;
    int          beats_sent;
    int          reads_sent;
    int          third_plane_beats;
    int          mask_settings;
    logic [15:0] hot_offsets [16];

    planar_video_ram_port u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    planar_video_ram_port_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tuser  (m_axis_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_errors     (error_count),
        .o_pending    (results_waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached with %0d results still waiting",
                     $time, results_waiting);
            $display("planar_video_ram_port_tb: done, errors");
            $finish;
        end
    end

    // Result-side ready. Runs of ready alternate with stalls, both of random length, so that
    // the stalls land on every step of the block's read-modify-write work. In the final
    // phase the receiver never stalls.
    always @(negedge i_clk) begin
        if (!i_rst_n || no_idling) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (stall_left == 0 && run_left == 0) begin
                run_left   = $urandom_range(1, 24);
                stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                run_left--;
            end
        end
    end

    // One register write: a setup cycle, then an access cycle held until pready.
    task automatic write_mask_register(input logic reg_sel, input logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drops the pixel stream and waits until the checker holds no prediction. Since every
    // beat yields a result, the block is idle at that point.
    task automatic wait_for_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (results_waiting != 0) @(negedge i_clk);
    endtask

    task automatic load_masks(input logic [63:0] two_plane, input logic [63:0] third_plane);
        wait_for_drain();
        write_mask_register(REG_TWO_BIT_MASKS, two_plane);
        write_mask_register(REG_THIRD_BIT_MASKS, third_plane);
        mask_settings++;
    endtask

    // Presents one pixel beat, sometimes after an idle gap, and returns once it has been
    // accepted. Valid stays high into the next call when no gap follows.
    task automatic send_pixel(input logic mode, input logic [15:0] off, input logic [7:0] data);
        @(negedge i_clk);
        if (!no_idling && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, off};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beats_sent++;
        if (mode == MODE_READ) reads_sent++;
        if (off[15:13] == THIRD_PLANE_SEL) third_plane_beats++;
    endtask

    // Masks as a real write PROM would hold them: each byte keeps every bit but those of
    // the one pixel that offset bits 2..0 name.
    function automatic logic [63:0] single_pixel_masks(input bit third_plane);
        logic [63:0] m;
        for (int k = 0; k < 8; k++)
            m[k*8 +: 8] = third_plane ? ~(8'h01 << k) : ~(8'h11 << (k % 4));
        return m;
    endfunction

    // Offsets cluster around a small set of hot spots so that reads see earlier writes.
    // The hot set mixes third-plane offsets with offsets below 0x2000, whose two-plane
    // bytes share RAM with the scattered third-plane bytes.
    function automatic logic [15:0] pick_offset();
        case ($urandom_range(0, 9))
            0, 1:    return 16'($urandom);
            2, 3:    return {THIRD_PLANE_SEL, 13'($urandom)};
            default: return hot_offsets[$urandom_range(0, 15)] ^ 16'($urandom_range(0, 7));
        endcase
    endfunction

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_WRITE;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        no_idling     = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with masks that take every new bit. The block is still clearing
        // its RAM, so the first beat waits for ready through that whole pass.
        load_masks(64'h0, 64'h0);
        send_pixel(MODE_WRITE, 16'h0000, 8'hc0);   // colour 3 fills the byte
        send_pixel(MODE_READ,  16'h0000, 8'h00);
        send_pixel(MODE_WRITE, 16'h0001, 8'h00);   // colour 0 clears it
        send_pixel(MODE_READ,  16'h0001, 8'hff);
        send_pixel(MODE_WRITE, 16'h0002, 8'h40);   // low nibble only
        send_pixel(MODE_READ,  16'h0002, 8'h00);
        send_pixel(MODE_WRITE, 16'h0003, 8'h80);   // high nibble only
        send_pixel(MODE_READ,  16'h0003, 8'h00);
        send_pixel(MODE_WRITE, 16'hffff, 8'hff);   // highest offset, third plane set
        send_pixel(MODE_READ,  16'hffff, 8'h00);
        send_pixel(MODE_WRITE, 16'he000, 8'h20);   // third plane set, colour 0
        send_pixel(MODE_READ,  16'he000, 8'h00);
        send_pixel(MODE_WRITE, 16'he000, 8'hdf);   // third plane clear, colour 3
        send_pixel(MODE_READ,  16'he000, 8'h00);
        send_pixel(MODE_READ,  16'hdfff, 8'h00);   // bits 15..13 not all set
        send_pixel(MODE_WRITE, 16'h7fff, 8'hff);
        send_pixel(MODE_READ,  16'h7fff, 8'h00);
        send_pixel(MODE_READ,  16'h1fff, 8'h00);   // shares RAM with third-plane bytes
        send_pixel(MODE_READ,  16'h0800, 8'h00);

        // Masks that keep every old bit: writes must leave the RAM alone.
        load_masks('1, '1);
        send_pixel(MODE_WRITE, 16'h0000, 8'h00);
        send_pixel(MODE_WRITE, 16'hffff, 8'h00);
        send_pixel(MODE_READ,  16'h0000, 8'h00);
        send_pixel(MODE_READ,  16'hffff, 8'h00);

        // Per-pixel masks: neighbours in the same byte must survive.
        load_masks(single_pixel_masks(1'b0), single_pixel_masks(1'b1));
        send_pixel(MODE_WRITE, 16'he005, 8'he0);
        send_pixel(MODE_READ,  16'he005, 8'h00);
        send_pixel(MODE_READ,  16'he004, 8'h00);

        // Random phases, each under a freshly loaded pair of masks. The last one runs with no
        // idling on either side so back-to-back accepts are seen as well.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       load_masks(64'h0, 64'h0);
                1:       load_masks('1, '1);
                3:       load_masks({$urandom, $urandom}, {$urandom, $urandom});
                5:       load_masks({$urandom, $urandom}, single_pixel_masks(1'b1));
                6:       load_masks(single_pixel_masks(1'b0), 64'h0);
                default: load_masks(single_pixel_masks(1'b0), single_pixel_masks(1'b1));
            endcase
            foreach (hot_offsets[h])
                hot_offsets[h] = h[0] ? {THIRD_PLANE_SEL, 13'($urandom)}
                                      : {3'b000, 13'($urandom)};
            if (phase == RANDOM_PHASES - 1) no_idling = 1'b1;
            for (int n = 0; n < BEATS_PER_PHASE; n++)
                send_pixel($urandom_range(0, 1) ? MODE_READ : MODE_WRITE, pick_offset(),
                           8'($urandom_range(0, 255)));
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d pixel beats (%0d reads, %0d on the third-plane path).",
                 beats_sent, reads_sent, third_plane_beats);
        $display("Used %0d mask settings, from keep-nothing to keep-everything.",
                 mask_settings);
        if (error_count == 0 && results_waiting == 0) begin
            $display("planar_video_ram_port_tb: done, clean");
        end else begin
            $display("planar_video_ram_port_tb: done, errors");
        end
        $finish;
    end

endmodule
